// ----- sv/i2f_pkg.sv -----
`default_nettype none

package i2f_pkg;

    localparam int INT_W       = 32;
    localparam int FLOAT_W     = 32;
    localparam int FRAC_BITS   = 23;
    localparam int EXP_W       = 8;
    localparam int POS_W       = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [EXP_W-1:0] EXP_BIAS = 8'h7f;

    // Word handed from the classify stage to the rounding stage
    typedef struct packed {
        logic             sign;
        logic             zero;
        logic [POS_W-1:0] lead_pos;
        logic [INT_W-1:0] mag;
    } t_entry;

endpackage

`default_nettype wire

// ----- sv/i2f_front.sv -----
`default_nettype none

module i2f_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic [i2f_pkg::INT_W-1:0] i_int_value,
    output logic                           o_valid,
    output i2f_pkg::t_entry                o_entry,
    input  wire logic                      i_ready
);
    import i2f_pkg::*;

    logic             r_valid;
    logic             n_valid;
    t_entry           r_entry;
    t_entry           n_entry;
    logic             take;
    logic [INT_W-1:0] mag;
    logic [15:0]      win16;
    logic [7:0]       win8;
    logic [3:0]       win4;
    logic [1:0]       win2;
    logic [POS_W-1:0] pos;

    assign o_full  = r_valid && !i_ready;
    assign take    = i_push && !o_full;
    assign o_valid = r_valid;
    assign o_entry = r_entry;

    // Magnitude, then a five-level halving search for the leading one
    always_comb begin
        mag    = i_int_value[INT_W-1] ? (INT_W'(0) - i_int_value) : i_int_value;
        pos[4] = |mag[31:16];
        win16  = pos[4] ? mag[31:16] : mag[15:0];
        pos[3] = |win16[15:8];
        win8   = pos[3] ? win16[15:8] : win16[7:0];
        pos[2] = |win8[7:4];
        win4   = pos[2] ? win8[7:4] : win8[3:0];
        pos[1] = |win4[3:2];
        win2   = pos[1] ? win4[3:2] : win4[1:0];
        pos[0] = win2[1];

        n_entry.sign     = i_int_value[INT_W-1];
        n_entry.zero     = (mag == '0);
        n_entry.lead_pos = pos;
        n_entry.mag      = mag;
    end

    always_comb begin
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_entry <= n_entry;
        end
    end

endmodule

`default_nettype wire

// ----- sv/i2f_queue.sv -----
`default_nettype none

module i2f_queue #(
    parameter int DEPTH = i2f_pkg::QUEUE_DEPTH
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  i2f_pkg::t_entry i_entry,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_valid,
    output i2f_pkg::t_entry o_entry
);
    import i2f_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count missed a push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with pointers apart");
`endif

endmodule

`default_nettype wire

// ----- sv/i2f_back.sv -----
`default_nettype none

module i2f_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  i2f_pkg::t_entry                  i_entry,
    output logic                             o_take,
    output logic                             o_empty,
    input  wire logic                        i_pop,
    output logic [i2f_pkg::FLOAT_W-1:0]      o_float_word
);
    import i2f_pkg::*;

    logic               r_valid;
    logic               n_valid;
    logic [FLOAT_W-1:0] r_word;
    logic [FLOAT_W-1:0] n_word;
    logic [INT_W-1:0]   norm;
    logic [FRAC_BITS:0] kept;
    logic               guard;
    logic               sticky;
    logic               round_up;
    logic [FRAC_BITS+1:0] sum;
    logic [EXP_W-1:0]   exp_f;
    logic [FRAC_BITS-1:0] frac;

    assign o_empty      = !r_valid;
    assign o_float_word = r_word;
    assign o_take       = i_valid && (!r_valid || i_pop);

    // Leading one to bit 31, round to nearest even on the low eight bits
    always_comb begin
        norm     = i_entry.mag << (~i_entry.lead_pos);
        kept     = norm[INT_W-1 -: FRAC_BITS+1];
        guard    = norm[7];
        sticky   = |norm[6:0];
        round_up = guard && (sticky || kept[0]);
        sum      = {1'b0, kept} + (FRAC_BITS+2)'(round_up);
        exp_f    = EXP_W'(i_entry.lead_pos) + EXP_BIAS + EXP_W'(sum[FRAC_BITS+1]);
        frac     = sum[FRAC_BITS+1] ? '0 : sum[FRAC_BITS-1:0];
        if (i_entry.zero) begin
            n_word = '0;
        end else begin
            n_word = {i_entry.sign, exp_f, frac};
        end
    end

    always_comb begin
        if (o_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

// ----- sv/int32_to_float32_converter.sv -----
`default_nettype none

// Channel   Direction  Handshake           Word
// input     in         push / full         i_int_value  (signed 32-bit integer)
// result    out        empty / pop         o_float_word (IEEE 754 single bits)
//
// One word enters per cycle and one result leaves per cycle when pop keeps up.
// An accepted word reaches the result ports by way of the classify register,
// the queue and the rounding output register, in that order.
// Reset (synchronous, active low) clears all valid state and the queue pointers.
// A stalled result holds in the output register; that register, the QUEUE_DEPTH
// queue slots and the classify register take QUEUE_DEPTH + 2 words before full rises.

module int32_to_float32_converter #(
    parameter int QUEUE_DEPTH = i2f_pkg::QUEUE_DEPTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        push,
    output logic                             full,
    input  wire logic [i2f_pkg::INT_W-1:0]   i_int_value,
    output logic                             empty,
    input  wire logic                        pop,
    output logic [i2f_pkg::FLOAT_W-1:0]      o_float_word
);
    import i2f_pkg::*;

    // Classify stage to queue
    logic   front_valid;
    t_entry front_entry;
    logic   queue_full;

    // Queue to rounding stage
    logic   queue_valid;
    t_entry queue_entry;
    logic   back_take;

    // Take the integer, form sign and magnitude, find the leading one
    i2f_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_int_value (i_int_value),
        .o_valid     (front_valid),
        .o_entry     (front_entry),
        .i_ready     (!queue_full)
    );

    // Decouple classify from rounding so each side can stall alone
    i2f_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_entry (front_entry),
        .o_full  (queue_full),
        .i_pop   (back_take),
        .o_valid (queue_valid),
        .o_entry (queue_entry)
    );

    // Normalize, round to nearest even, pack and hold the word until popped
    i2f_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .i_entry      (queue_entry),
        .o_take       (back_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_float_word (o_float_word)
    );

endmodule

`default_nettype wire

// ----- tb/tb_int32_to_float32_converter.sv -----
`default_nettype none

module tb_int32_to_float32_converter;

    import i2f_pkg::*;

    // Cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT  = 2000;
    // Receiver hold-off used to back the block up into full
    localparam int HOLD_CYCLES  = 60;
    // Extra cycles after the last result, before the check for results that never arrived
    localparam int TAIL_CYCLES  = 12;
    localparam int RANDOM_WORDS = 138;
    localparam int BURST_WORDS  = 16;
    localparam int ROW_COUNT    = 20;

    typedef struct {
        logic [INT_W-1:0]   value;
        bit                 typed;
        logic [FLOAT_W-1:0] want_word;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 push;
    logic                 full;
    logic [INT_W-1:0]     i_int_value;
    logic                 empty;
    logic                 pop;
    logic [FLOAT_W-1:0]   o_float_word;

    // Typed expectation travels with the word so the monitor can pick it up
    bit                   row_typed;
    logic [FLOAT_W-1:0]   row_float;

    logic [FLOAT_W-1:0]   float_due[$];

    int                   sender_idle_pct;
    int                   receiver_idle_pct;
    bit                   hold_request;
    int                   words_sent;
    int                   results_checked;
    int                   failures;
    int                   quiet_cycles;

    // Directed words: extremes and every rounding corner. Rows whose answer is
    // obvious carry it; the rest lean on the predictor.
    t_row directed_rows [ROW_COUNT] = '{
        '{32'h0000_0000, 1'b1, 32'h0000_0000},  // zero gives positive zero
        '{32'h0000_0001, 1'b1, 32'h3F80_0000},  // one
        '{32'hFFFF_FFFF, 1'b1, 32'hBF80_0000},  // minus one
        '{32'h7FFF_FFFF, 1'b1, 32'h4F00_0000},  // largest positive, carries up
        '{32'h8000_0000, 1'b1, 32'hCF00_0000},  // most negative, exact
        '{32'h8000_0001, 1'b1, 32'hCF00_0000},  // most negative plus one, carries
        '{32'h00FF_FFFF, 1'b1, 32'h4B7F_FFFF},  // widest exact magnitude
        '{32'h0100_0000, 1'b0, 32'h0},          // first magnitude that drops a bit
        '{32'h0100_0001, 1'b0, 32'h0},          // halfway, even neighbor below
        '{32'h0100_0003, 1'b0, 32'h0},          // halfway, odd kept bit rounds up
        '{32'h01FF_FFFF, 1'b0, 32'h0},          // rounding carry into exponent
        '{32'hFE00_0001, 1'b0, 32'h0},          // negative rounding carry
        '{32'h0200_0002, 1'b0, 32'h0},          // two dropped bits, halfway, even
        '{32'h0200_0006, 1'b0, 32'h0},          // two dropped bits, halfway, odd
        '{32'h0200_0003, 1'b0, 32'h0},          // above halfway
        '{32'h4000_0040, 1'b0, 32'h0},          // seven dropped bits, halfway, even
        '{32'h4000_00C0, 1'b0, 32'h0},          // seven dropped bits, halfway, odd
        '{32'h7FFF_FFBF, 1'b0, 32'h0},          // just below halfway near the top
        '{32'h0000_0002, 1'b0, 32'h0},          // small power of two
        '{32'hFF80_0000, 1'b0, 32'h0}           // negative power of two, exact
    };

    int32_to_float32_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_int_value  (i_int_value),
        .empty        (empty),
        .pop          (pop),
        .o_float_word (o_float_word)
    );

    // Round-to-nearest-even conversion of a two's complement integer
    function automatic logic [FLOAT_W-1:0] int_to_single_bits(input logic [INT_W-1:0] value);
        logic               sign;
        logic [INT_W-1:0]   mag;
        logic [INT_W-1:0]   kept;
        logic [INT_W-1:0]   rest;
        logic [INT_W-1:0]   half_ulp;
        logic [INT_W-1:0]   aligned;
        logic [EXP_W-1:0]   expo;
        logic [22:0]        frac;
        int                 lead;
        int                 drop;
        sign = value[INT_W-1];
        mag  = sign ? (~value + 1'b1) : value;
        if (mag == '0) begin
            return '0;
        end
        lead = 0;
        for (int b = 0; b < INT_W; b++) begin
            if (mag[b]) begin
                lead = b;
            end
        end
        expo = EXP_W'(lead) + EXP_BIAS;
        if (lead <= FRAC_BITS) begin
            aligned = mag << (FRAC_BITS - lead);
            frac    = aligned[22:0];
        end else begin
            drop     = lead - FRAC_BITS;
            kept     = mag >> drop;
            rest     = mag & ((32'd1 << drop) - 1);
            half_ulp = 32'd1 << (drop - 1);
            if (rest > half_ulp || (rest == half_ulp && kept[0])) begin
                kept = kept + 1'b1;
            end
            // A carry past the hidden bit renormalizes
            if (kept[FRAC_BITS+1]) begin
                kept = kept >> 1;
                expo = expo + 1'b1;
            end
            frac = kept[22:0];
        end
        return {sign, expo, frac};
    endfunction

    // Mix of uniform words, every leading-one position, exact ties, near-carry
    // and small magnitudes, each with a random sign
    function automatic logic [INT_W-1:0] pick_int_value();
        int unsigned        kind;
        int unsigned        lead;
        int unsigned        drop;
        logic [INT_W-1:0]   mag;
        kind = $urandom_range(0, 9);
        lead = $urandom_range(0, 31);
        case (kind) inside
            [0:3]: begin
                return $urandom;
            end
            [4:6]: begin
                mag = ($urandom | 32'h8000_0000) >> (31 - lead);
            end
            7: begin
                lead = $urandom_range(24, 30);
                drop = lead - FRAC_BITS;
                mag  = (32'd1 << lead) | ($urandom & ((32'd1 << lead) - 1));
                mag  = (mag & ~((32'd1 << drop) - 1)) | (32'd1 << (drop - 1));
            end
            8: begin
                lead = $urandom_range(24, 31);
                mag  = (32'hFFFF_FFFF >> (31 - lead)) - $urandom_range(0, 7);
            end
            default: begin
                mag = $urandom_range(0, 16);
            end
        endcase
        return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
    endfunction

    // Offer one word, idling first at the current sender rate, and hold it
    // until the block takes it
    task automatic send_word(input logic [INT_W-1:0] value, input bit typed,
                             input logic [FLOAT_W-1:0] want_word);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_int_value <= value;
        row_typed   <= typed;
        row_float   <= want_word;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        words_sent++;
    endtask

    // Drop push and hold off until every outstanding result is back
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (float_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            send_word(pick_int_value(), 1'b0, '0);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    // Receiver: pop at the current rate, or hold pop low for a long stretch
    // when asked so the block fills and pushes back on the sender
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                repeat (HOLD_CYCLES) begin
                    pop <= 1'b0;
                    @(posedge i_clk);
                end
            end
            pop <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Monitor: check popped results against the oldest expectation, then log
    // the expectation for any word accepted at this edge; also run the watchdog
    always @(posedge i_clk) begin
        logic [FLOAT_W-1:0] due_bits;
        bit                 moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                moved = 1'b1;
                if (float_due.size() == 0) begin
                    $error("float_word: no result expected, got %h", o_float_word);
                    failures++;
                end else begin
                    due_bits = float_due.pop_front();
                    results_checked++;
                    if (o_float_word !== due_bits) begin
                        $error("float_word: expected %h, got %h", due_bits, o_float_word);
                        failures++;
                    end
                end
            end
            if (push && !full) begin
                moved = 1'b1;
                float_due.push_back(row_typed ? row_float : int_to_single_bits(i_int_value));
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        push              <= 1'b0;
        i_int_value       <= '0;
        row_typed         <= 1'b0;
        row_float         <= '0;
        i_rst_n           <= 1'b0;
        hold_request      = 1'b0;
        sender_idle_pct   = 34;
        receiver_idle_pct = 49;
        words_sent        = 0;
        results_checked   = 0;
        failures          = 0;
        quiet_cycles      = 0;

        repeat (3) begin
            @(posedge i_clk);
        end
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Phase one: sender idles lightly, receiver heavily
        for (int r = 0; r < ROW_COUNT; r++) begin
            send_word(directed_rows[r].value, directed_rows[r].typed,
                      directed_rows[r].want_word);
        end
        send_random(RANDOM_WORDS);
        drain_results();

        // Phase two: roles swapped; pause midway until the pipe is empty
        sender_idle_pct   = 49;
        receiver_idle_pct = 34;
        send_random(RANDOM_WORDS / 2);
        drain_results();
        send_random(RANDOM_WORDS / 2);
        drain_results();

        // Phase three: no idling; stall the receiver while words keep coming
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_request      = 1'b1;
        send_random(BURST_WORDS);
        send_random(RANDOM_WORDS);
        drain_results();

        repeat (TAIL_CYCLES) begin
            @(posedge i_clk);
        end
        if (float_due.size() != 0) begin
            $error("float_word: %0d results never arrived", float_due.size());
            failures++;
        end

        $display("converted %0d integers (%0d directed corners, the rest random)",
                 words_sent, ROW_COUNT);
        $display("checked %0d float words under three idle mixes and a full stall",
                 results_checked);
        if (failures == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
